// ===== hw/rtl/trs_pkg.sv =====
package trs_pkg;

  // field widths
  localparam int unsigned GATE_W     = 16;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned RPC_W      = 8;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned SMOOTH_W   = 11;
  localparam int unsigned DISP_W     = 14;
  localparam int unsigned TGT_W      = 32;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W    = 32;
  localparam int unsigned MUL_B_W    = 11;
  localparam int unsigned MUL_P_W    = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RPM_PER_COUNT = 2'd0;
  localparam cfg_idx_t CFG_TIMEOUT_MS    = 2'd1;
  localparam cfg_idx_t CFG_SMOOTHING     = 2'd2;

  localparam logic [RPC_W-1:0]    RPC_RESET    = 8'd60;
  localparam logic [TMO_W-1:0]    TMO_RESET    = 16'd1000;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 11'd307;

  // q10 smoothing
  localparam int unsigned         SMOOTH_SHIFT = 10;
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE   = 11'd1024;

  localparam logic [DISP_W-1:0]   DISP_MAX     = 14'd9999;

endpackage

// ===== hw/rtl/trs_div.sv =====
module trs_div #(
  parameter int unsigned DW = 34,
  parameter int unsigned VW = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] dsr_q;
  logic [VW:0]   trial;
  logic          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    ge    = (trial >= {1'b0, dsr_q});
    rem_d = ge ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
    quo_d = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/tachometer_rpm_smoother_top.sv =====
// sequence: a beat without a new count goes from accept through the smoothing multiply,
// update and output states; a beat with a nonzero count first sums the n valid ring
// entries one a cycle, multiplies, runs the serial divider of DIV_W bits (34 by default)
// that forms the mean and saturates the target
// throughput: one beat at a time, input stalled until the result is registered,
// longer while the previous result is still stalled at the output
// reset: async active low, registers at their defaults, ring empty, output valid low
module tachometer_rpm_smoother_top #(
  parameter int unsigned AVG_DEPTH = 4,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [trs_pkg::GATE_W-1:0]      gate_count_i,
  input  logic [trs_pkg::NOW_W-1:0]       now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [trs_pkg::DISP_W-1:0]      display_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [trs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [trs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import trs_pkg::*;

  localparam int unsigned PTR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int unsigned SUM_W  = GATE_W + $clog2(AVG_DEPTH);
  localparam int unsigned SP_W   = SUM_W + RPC_W;
  localparam int unsigned RAW_W  = SP_W + FRAC_BITS;
  localparam int unsigned DIV_W  = (RAW_W > TGT_W) ? RAW_W : TGT_W + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_DGO  = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_SAT  = 4'd5;
  localparam logic [3:0] ST_SMUL = 4'd6;
  localparam logic [3:0] ST_UPD  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]          state_q, state_d;

  logic [RPC_W-1:0]    rpc_q;
  logic [TMO_W-1:0]    tmo_q;
  logic [SMOOTH_W-1:0] smooth_q;

  logic [GATE_W-1:0]   ring_q [AVG_DEPTH];
  logic [PTR_W-1:0]    wp_q;
  logic                full_q;
  logic [NOW_W-1:0]    last_q;
  logic [TGT_W-1:0]    target_q;
  logic [TGT_W-1:0]    cur_q;

  logic [CNT_W-1:0]    n_q;
  logic [CNT_W-1:0]    idx_q;
  logic [SUM_W-1:0]    sum_q;
  logic [MUL_P_W-1:0]  prod_q;
  logic                up_q;

  logic                out_valid_q;
  logic [DISP_W-1:0]   out_data_q;

  logic                accept;
  logic                has_count;
  logic                wrap;
  logic [NOW_W-1:0]    elapsed;
  logic                timed_out;
  logic [CNT_W-1:0]    wp_next;
  logic [CNT_W-1:0]    n_next;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [SMOOTH_W-1:0] s_eff;
  logic                ge;
  logic [TGT_W-1:0]    diff;

  logic                div_start;
  logic                div_busy;
  logic [DIV_W-1:0]    div_quo;
  logic [DIV_W-1:0]    dividend;

  logic [MUL_P_W:0]    rnd_up;
  logic [TGT_W-1:0]    step_dn;
  logic [TGT_W:0]      disp_sum;
  logic [TGT_W-FRAC_BITS:0] disp_raw;
  logic [DISP_W-1:0]   disp;
  logic                out_free;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign has_count = kind_i && (gate_count_i != '0);
  assign wrap      = (wp_q == PTR_W'(AVG_DEPTH - 1));
  assign wp_next   = wrap ? '0 : CNT_W'(wp_q) + 1'b1;
  assign n_next    = (wrap || full_q) ? CNT_W'(AVG_DEPTH) : wp_next;
  assign elapsed   = now_ms_i - last_q;
  assign timed_out = (elapsed > NOW_W'(tmo_q));

  assign s_eff = (smooth_q > SMOOTH_ONE) ? SMOOTH_ONE : smooth_q;
  assign ge    = (target_q >= cur_q);
  assign diff  = ge ? (target_q - cur_q) : (cur_q - target_q);

  // shared multiplier: rpm factor times count sum, then delta times smoothing
  always_comb begin
    if (state_q == ST_MUL) begin
      mul_a = MUL_A_W'(sum_q);
      mul_b = MUL_B_W'(rpc_q);
    end else begin
      mul_a = diff;
      mul_b = s_eff;
    end
    mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  assign dividend  = DIV_W'({prod_q[SP_W-1:0], {FRAC_BITS{1'b0}}});
  assign div_start = (state_q == ST_DGO);

  trs_div #(
    .DW (DIV_W),
    .VW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // downward step magnitude rounds up, so the smoothed value rounds toward minus infinity
  assign rnd_up  = {1'b0, prod_q} + (MUL_P_W + 1)'((1 << SMOOTH_SHIFT) - 1);
  assign step_dn = rnd_up[SMOOTH_SHIFT+TGT_W-1:SMOOTH_SHIFT];

  assign disp_sum = {1'b0, cur_q} + (TGT_W + 1)'(1 << (FRAC_BITS - 1));
  assign disp_raw = disp_sum[TGT_W:FRAC_BITS];
  assign disp     = (disp_raw > (TGT_W - FRAC_BITS + 1)'(DISP_MAX))
                    ? DISP_MAX : DISP_W'(disp_raw);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = has_count ? ST_SUM : ST_SMUL;
        end
      end
      ST_SUM: begin
        if (idx_q + 1'b1 == n_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DGO;
      ST_DGO:  state_d = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT:  state_d = ST_SMUL;
      ST_SMUL: state_d = ST_UPD;
      ST_UPD:  state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rpc_q       <= RPC_RESET;
      tmo_q       <= TMO_RESET;
      smooth_q    <= SMOOTH_RESET;
      wp_q        <= '0;
      full_q      <= 1'b0;
      last_q      <= '0;
      target_q    <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_idx_i)
          CFG_RPM_PER_COUNT: rpc_q    <= cfg_data_i[RPC_W-1:0];
          CFG_TIMEOUT_MS:    tmo_q    <= cfg_data_i[TMO_W-1:0];
          CFG_SMOOTHING:     smooth_q <= cfg_data_i[SMOOTH_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (has_count) begin
          last_q <= now_ms_i;
          wp_q   <= PTR_W'(wp_next);
          if (wrap) begin
            full_q <= 1'b1;
          end
        end else if (timed_out) begin
          target_q <= '0;
          wp_q     <= '0;
          full_q   <= 1'b0;
        end
      end

      if (state_q == ST_SAT) begin
        target_q <= (|div_quo[DIV_W-1:TGT_W]) ? '1 : div_quo[TGT_W-1:0];
      end

      if (state_q == ST_UPD) begin
        if (up_q) begin
          cur_q <= cur_q + prod_q[SMOOTH_SHIFT+TGT_W-1:SMOOTH_SHIFT];
        end else begin
          cur_q <= cur_q - step_dn;
        end
      end

      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed; entries past the fill point are never read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (has_count) begin
        ring_q[wp_q] <= gate_count_i;
      end
      n_q   <= n_next;
      idx_q <= '0;
      sum_q <= '0;
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_q + SUM_W'(ring_q[idx_q[PTR_W-1:0]]);
      idx_q <= idx_q + 1'b1;
    end
    if (state_q == ST_MUL || state_q == ST_SMUL) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_SMUL) begin
      up_q <= ge;
    end
    if (state_q == ST_FIN && out_free) begin
      out_data_q <= disp;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign display_value_o = out_data_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import trs_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned FRAC = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_LONG} rx_mode_e;

  // shadow of the smoother: config, ring, timing and fixed point rpm values
  class rpm_tracker;
    logic [RPC_W-1:0] rpc;
    logic [TMO_W-1:0] tmo;
    logic [SMOOTH_W-1:0] smooth;
    logic [GATE_W-1:0] ring [DEPTH];
    logic [1:0] wpos;
    logic full;
    logic [NOW_W-1:0] last_sig;
    logic [TGT_W-1:0] target;
    logic [TGT_W-1:0] current;
    logic [DISP_W-1:0] display_due [$];
    int errors = 0;

    function new();
      rpc = RPC_RESET;
      tmo = TMO_RESET;
      smooth = SMOOTH_RESET;
      clear_ring();
      last_sig = '0;
      target = '0;
      current = '0;
    endfunction

    function void clear_ring();
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      wpos = '0;
      full = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RPM_PER_COUNT: rpc = data[RPC_W-1:0];
        CFG_TIMEOUT_MS: tmo = data[TMO_W-1:0];
        CFG_SMOOTHING: smooth = data[SMOOTH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_pass(logic k, logic [GATE_W-1:0] c, logic [NOW_W-1:0] t);
      logic [63:0] sum;
      logic [63:0] q;
      logic [63:0] s;
      logic [63:0] d;
      logic [63:0] shown;
      logic [NOW_W-1:0] elapsed;
      int unsigned n;
      if (k && c != '0) begin
        last_sig = t;
        ring[wpos] = c;
        if (wpos == 2'd3) full = 1'b1;
        wpos = wpos + 2'd1;
        n = full ? DEPTH : 32'(wpos);
        sum = '0;
        for (int i = 0; i < n; i++) sum += 64'(ring[i]);
        q = ((sum * rpc) << FRAC) / n;
        target = (q > 64'hFFFF_FFFF) ? '1 : q[TGT_W-1:0];
      end
      // count first, so a beat with a count never times out
      elapsed = t - last_sig;
      if (elapsed > tmo) begin
        target = '0;
        clear_ring();
      end
      s = 64'((smooth > SMOOTH_ONE) ? SMOOTH_ONE : smooth);
      if (target >= current) begin
        d = 64'(target - current);
        current = current + 32'((d * s) >> SMOOTH_SHIFT);
      end else begin
        d = 64'(current - target);
        current = current - 32'((d * s + SMOOTH_ONE - 1) >> SMOOTH_SHIFT);
      end
      shown = (64'(current) + (64'd1 << (FRAC - 1))) >> FRAC;
      if (shown > DISP_MAX) shown = 64'(DISP_MAX);
      display_due.push_back(shown[DISP_W-1:0]);
    endfunction

    function void check_display(logic [DISP_W-1:0] got);
      logic [DISP_W-1:0] want;
      if (display_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual display_value %0d", $time, got);
      end else begin
        want = display_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: display_value mismatch: expected %0d, actual %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic kind_i;
  logic [GATE_W-1:0] gate_count_i;
  logic [NOW_W-1:0] now_ms_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [DISP_W-1:0] display_value_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rpm_tracker sb;
  int burst_left = 0;
  int idle_cycles = 0;
  int mode_left = 0;
  int hold_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  logic [NOW_W-1:0] clock_ms = '0;

  tachometer_rpm_smoother_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .gate_count_i    (gate_count_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .display_value_o (display_value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // receiver stall pattern, switching between modes now and then
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: out_stall_i = 1'b0;
      RX_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i = ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          out_stall_i = ~out_stall_i;
          hold_left = $urandom_range(1, 20);
        end
        hold_left--;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_display(display_value_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic k, input logic [GATE_W-1:0] c,
                           input logic [NOW_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i = k;
    gate_count_i = c;
    now_ms_i = t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pass(k, c, t);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.display_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    repeat ($urandom_range(0, 3)) @(negedge clk_i);
  endtask

  // upper data bits beyond each register width are junk on purpose
  task automatic apply_settings(input logic [RPC_W-1:0] rpc, input logic [TMO_W-1:0] tmo,
                                input logic [SMOOTH_W-1:0] sm);
    cfg_write(CFG_RPM_PER_COUNT, {8'($urandom()), rpc});
    cfg_write(CFG_TIMEOUT_MS, tmo);
    cfg_write(CFG_SMOOTHING, {5'($urandom()), sm});
    cfg_write(CFG_UNUSED, 16'($urandom()));
  endtask

  task automatic random_items(input int count);
    logic k;
    logic [GATE_W-1:0] c;
    logic [NOW_W-1:0] t;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // keep the signal alive
        t = clock_ms + $urandom_range(0, (sb.tmo > 1) ? sb.tmo / 2 : 1);
      end else if (sel < 82) begin
        // right around the timeout boundary
        t = sb.last_sig + sb.tmo + $urandom_range(0, 2) - 1;
      end else if (sel < 90) begin
        t = clock_ms + $urandom();
      end else if (sel < 95) begin
        t = clock_ms - $urandom_range(1, 100);
      end else begin
        t = $urandom();
      end
      k = ($urandom_range(0, 99) < 75);
      sel = $urandom_range(0, 99);
      if (sel < 70) c = 16'($urandom_range(1, 200));
      else if (sel < 80) c = '0;
      else if (sel < 90) c = 16'($urandom());
      else if (sel < 95) c = '1;
      else c = 16'd1;
      clock_ms = t;
      send_item(k, c, t);
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    gate_count_i = '0;
    now_ms_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: 60 rpm per count, 1000 ms timeout
    send_item(1'b0, 16'd0, 32'd0);
    send_item(1'b1, 16'd0, 32'd10);           // zero count is no count
    send_item(1'b1, 16'd100, 32'd20);
    send_item(1'b0, 16'hFFFF, 32'd30);        // count ignored without kind
    send_item(1'b1, 16'hFFFF, 32'd40);
    send_item(1'b1, 16'hFFFF, 32'd50);
    send_item(1'b1, 16'hFFFF, 32'd60);        // ring full
    send_item(1'b1, 16'd1, 32'd70);           // ring wraps
    send_item(1'b0, 16'd0, 32'd1070);         // exactly at timeout, kept
    send_item(1'b0, 16'd0, 32'd1071);         // one past timeout
    send_item(1'b0, 16'd0, 32'd1080);
    send_item(1'b1, 16'd50, 32'hFFFF_FFF0);
    send_item(1'b0, 16'd0, 32'h0000_0010);    // elapsed across the wrap
    send_item(1'b1, 16'hFFFF, 32'h0000_0020);
    send_item(1'b0, 16'd0, 32'hFFFF_FF00);    // time goes backward
    send_item(1'b1, 16'd1, 32'hFFFF_FFFF);
    send_item(1'b1, 16'd2, 32'hFFFF_FFFF);
    send_item(1'b0, 16'h5A5A, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_FFFF;
    drain_results();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: apply_settings(8'd255, 16'hFFFF, 11'd1024);
        1: apply_settings(8'd1, 16'd1, 11'd0);
        2: apply_settings(8'd0, 16'd0, 11'd2047);
        default: apply_settings(8'($urandom_range(1, 255)), 16'($urandom_range(1, 5000)),
                                11'($urandom_range(0, 2047)));
      endcase
      random_items((p < 3) ? 100 : 150);
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.display_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
